### hdl/assert_macros.svh
// Assertion macros shared by the scheduler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PPS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PPS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/pps_pkg.sv
// Types, codes and helper functions of the preemptive priority scheduler.
package pps_pkg;

    localparam int CMD_W    = 2;
    localparam int ID_W     = 16;
    localparam int ARR_W    = 16;
    localparam int BURST_W  = 16;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 3;
    localparam int TIME_W   = 24;

    // Command codes on the input channel.
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Status codes on the result channel.
    localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_IDLE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RAN     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DONE    = 3'd5;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // Command queue between the front end and the executor.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_TICK,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [ID_W-1:0]    task_id;
        logic [ARR_W-1:0]   arrival_time;
        logic [BURST_W-1:0] burst_length;
        logic [PRIO_W-1:0]  prio_level;
    } cmd_item_t;

    typedef struct packed {
        logic      valid;
        cmd_item_t item;
    } q_push_t;

    typedef struct packed {
        logic      valid;
        cmd_item_t item;
    } q_head_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TIME_W-1:0]   tick_time;
        logic [ID_W-1:0]     run_id;
        logic [BURST_W-1:0]  units_left;
        logic [TIME_W-1:0]   first_run_time;
        logic [TIME_W-1:0]   finish_time;
        logic [TIME_W-1:0]   turnaround;
        logic [TIME_W-1:0]   waiting;
    } rsp_item_t;

    // Fields read during the priority scan.
    typedef struct packed {
        logic [ARR_W-1:0]  arrival;
        logic [PRIO_W-1:0] prio;
    } sel_rec_t;

    // Fields read and rewritten when a task runs.
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] left;
        logic [TIME_W-1:0]  start;
    } task_rec_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_UPDATE,
        S_TURN,
        S_WAIT
    } exec_state_t;

    // Time increment that sticks at the largest value.
    function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] t);
        return (t == TIME_MAX) ? t : t + 1'b1;
    endfunction

    // Difference floored at zero.
    function automatic logic [TIME_W-1:0] floor_sub(input logic [TIME_W-1:0] a,
                                                    input logic [TIME_W-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

endpackage

### hdl/pps_if.sv
// Valid/ready channel interfaces for scheduler commands and results.
interface pps_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [pps_pkg::CMD_W-1:0]     cmd;
    logic [pps_pkg::ID_W-1:0]      task_id;
    logic [pps_pkg::ARR_W-1:0]     arrival_time;
    logic [pps_pkg::BURST_W-1:0]   burst_length;
    logic [pps_pkg::PRIO_W-1:0]    prio_level;

    modport source (output valid, cmd, task_id, arrival_time, burst_length, prio_level,
                    input ready);
    modport sink (input valid, cmd, task_id, arrival_time, burst_length, prio_level,
                  output ready);
endinterface

interface pps_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [pps_pkg::STATUS_W-1:0]  status;
    logic [pps_pkg::TIME_W-1:0]    tick_time;
    logic [pps_pkg::ID_W-1:0]      run_id;
    logic [pps_pkg::BURST_W-1:0]   units_left;
    logic [pps_pkg::TIME_W-1:0]    first_run_time;
    logic [pps_pkg::TIME_W-1:0]    finish_time;
    logic [pps_pkg::TIME_W-1:0]    turnaround;
    logic [pps_pkg::TIME_W-1:0]    waiting;

    modport source (output valid, status, tick_time, run_id, units_left, first_run_time,
                    finish_time, turnaround, waiting,
                    input ready);
    modport sink (input valid, status, tick_time, run_id, units_left, first_run_time,
                  finish_time, turnaround, waiting,
                  output ready);
endinterface

### hdl/pps_front.sv
// Front end: accepts command items, decodes them and pushes them into the queue.
module pps_front (
    pps_cmd_if.sink          cmd_ch,
    output pps_pkg::q_push_t push,
    input  logic             full
);
    import pps_pkg::*;

    // Items are taken whenever the queue has room; unknown commands are dropped.
    assign cmd_ch.ready = !full;

    always_comb
    begin
        push.valid             = 1'b0;
        push.item.op           = OP_LOAD;
        push.item.task_id      = cmd_ch.task_id;
        push.item.arrival_time = cmd_ch.arrival_time;
        push.item.burst_length = cmd_ch.burst_length;
        push.item.prio_level   = cmd_ch.prio_level;
        case (cmd_ch.cmd)
            CMD_LOAD:
            begin
                push.valid   = cmd_ch.valid && !full;
                push.item.op = OP_LOAD;
            end
            CMD_TICK:
            begin
                push.valid   = cmd_ch.valid && !full;
                push.item.op = OP_TICK;
            end
            CMD_CLEAR:
            begin
                push.valid   = cmd_ch.valid && !full;
                push.item.op = OP_CLEAR;
            end
            default:
            begin
                push.valid = 1'b0;
            end
        endcase
    end

endmodule

### hdl/pps_queue.sv
// Short command queue that decouples the front end from the executor.
`include "assert_macros.svh"

module pps_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  pps_pkg::q_push_t push,
    output logic             full,
    input  logic             pop,
    output pps_pkg::q_head_t head
);
    import pps_pkg::*;

    cmd_item_t         slot_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg;
    logic [QCNT_W-1:0] fill_next;

    assign full       = (fill_reg == QCNT_W'(QDEPTH));
    assign head.valid = (fill_reg != '0);
    assign head.item  = slot_mem[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push.valid)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push.valid && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push.valid)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_mem[wr_ptr_reg] <= push.item;
        end
    end

    `PPS_ASSERT_IMP(a_q_no_overflow, push.valid, fill_reg != QCNT_W'(QDEPTH), "queue overflow")
    `PPS_ASSERT_IMP(a_q_no_underflow, pop, fill_reg != '0, "queue underflow")
    `PPS_ASSERT_NXT(a_q_fill_up, push.valid && !pop, fill_reg == $past(fill_reg) + 1'b1, "fill")

endmodule

### hdl/pps_exec.sv
// Executor: task table, priority scan, run update and the result register.
`include "assert_macros.svh"

module pps_exec #(
    parameter int MAX_TASKS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pps_pkg::q_head_t   head,
    output logic               pop,
    output pps_pkg::rsp_item_t rsp_item,
    output logic               rsp_valid,
    input  logic               rsp_ready
);
    import pps_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TASKS);

    // Control state.
    exec_state_t          state_reg;
    exec_state_t          state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [TIME_W-1:0]    now_reg;
    logic [TIME_W-1:0]    now_next;
    logic [MAX_TASKS-1:0] done_reg;
    logic [MAX_TASKS-1:0] done_next;
    logic [MAX_TASKS-1:0] started_reg;
    logic [MAX_TASKS-1:0] started_next;
    logic [CNT_W-1:0]     scan_addr_reg;
    logic [CNT_W-1:0]     scan_addr_next;
    logic                 cmp_valid_reg;
    logic                 cmp_valid_next;
    logic                 found_reg;
    logic                 found_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;

    // Payload state.
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic [IDX_W-1:0]     cmp_idx_next;
    logic [PRIO_W-1:0]    best_prio_reg;
    logic [PRIO_W-1:0]    best_prio_next;
    logic [ARR_W-1:0]     best_arr_reg;
    logic [ARR_W-1:0]     best_arr_next;
    logic [IDX_W-1:0]     pick_reg;
    logic [IDX_W-1:0]     pick_next;
    logic [BURST_W-1:0]   burst_reg;
    logic [BURST_W-1:0]   burst_next;
    rsp_item_t            rsp_reg;
    rsp_item_t            rsp_next;

    // Table memories.
    sel_rec_t             sel_mem [MAX_TASKS];
    task_rec_t            rec_mem [MAX_TASKS];
    logic                 sel_we;
    logic [IDX_W-1:0]     sel_waddr;
    sel_rec_t             sel_wdata;
    logic [IDX_W-1:0]     sel_raddr;
    sel_rec_t             sel_rdata_reg;
    logic                 rec_we;
    logic [IDX_W-1:0]     rec_waddr;
    task_rec_t            rec_wdata;
    logic [IDX_W-1:0]     rec_raddr;
    task_rec_t            rec_rdata_reg;

    logic                 rsp_free;
    logic [BURST_W-1:0]   left_new;
    logic [TIME_W-1:0]    start_val;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign sel_raddr = scan_addr_reg[IDX_W-1:0];
    assign rec_raddr = pick_reg;
    assign left_new  = rec_rdata_reg.left - 1'b1;
    assign start_val = started_reg[pick_reg] ? rec_rdata_reg.start : now_reg;

    // Sequencer: command dispatch, scan, run update and completion figures.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        now_next       = now_reg;
        done_next      = done_reg;
        started_next   = started_reg;
        scan_addr_next = scan_addr_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        best_prio_next = best_prio_reg;
        best_arr_next  = best_arr_reg;
        pick_next      = pick_reg;
        burst_next     = burst_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        pop            = 1'b0;
        sel_we         = 1'b0;
        sel_waddr      = count_reg[IDX_W-1:0];
        sel_wdata.arrival = head.item.arrival_time;
        sel_wdata.prio    = head.item.prio_level;
        rec_we         = 1'b0;
        rec_waddr      = count_reg[IDX_W-1:0];
        rec_wdata.id    = head.item.task_id;
        rec_wdata.burst = head.item.burst_length;
        rec_wdata.left  = head.item.burst_length;
        rec_wdata.start = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (head.valid && rsp_free)
                begin
                    pop      = 1'b1;
                    rsp_next = '0;
                    case (head.item.op)
                        OP_LOAD:
                        begin
                            rsp_valid_next = 1'b1;
                            if (count_reg == CNT_MAX)
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                sel_we = 1'b1;
                                rec_we = 1'b1;
                                done_next[count_reg[IDX_W-1:0]] =
                                    (head.item.burst_length == '0);
                                started_next[count_reg[IDX_W-1:0]] = 1'b0;
                                count_next      = count_reg + 1'b1;
                                rsp_next.status = ST_LOADED;
                            end
                        end
                        OP_CLEAR:
                        begin
                            done_next       = '0;
                            started_next    = '0;
                            count_next      = '0;
                            now_next        = '0;
                            rsp_next.status = ST_CLEARED;
                            rsp_valid_next  = 1'b1;
                        end
                        OP_TICK:
                        begin
                            rsp_next.tick_time = now_reg;
                            scan_addr_next     = '0;
                            cmp_valid_next     = 1'b0;
                            found_next         = 1'b0;
                            state_next         = S_SCAN;
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b0;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Issue one table read per cycle.
                if (scan_addr_reg != count_reg)
                begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_addr_reg[IDX_W-1:0];
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                end
                // Compare the entry read in the previous cycle; strict less keeps ties.
                if (cmp_valid_reg)
                begin
                    if (!done_reg[cmp_idx_reg] &&
                        (TIME_W'(sel_rdata_reg.arrival) <= now_reg) &&
                        (!found_reg || (sel_rdata_reg.prio < best_prio_reg)))
                    begin
                        found_next     = 1'b1;
                        best_prio_next = sel_rdata_reg.prio;
                        best_arr_next  = sel_rdata_reg.arrival;
                        pick_next      = cmp_idx_reg;
                    end
                end
                else if (scan_addr_reg == count_reg)
                begin
                    if (found_reg)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        now_next        = sat_inc(now_reg);
                        rsp_next.status = ST_IDLE;
                        rsp_valid_next  = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
            end

            S_READ:
            begin
                state_next = S_UPDATE;
            end

            S_UPDATE:
            begin
                // Run the picked task for one unit.
                rec_we          = 1'b1;
                rec_waddr       = pick_reg;
                rec_wdata.id    = rec_rdata_reg.id;
                rec_wdata.burst = rec_rdata_reg.burst;
                rec_wdata.left  = left_new;
                rec_wdata.start = start_val;
                started_next[pick_reg] = 1'b1;
                now_next            = sat_inc(now_reg);
                rsp_next.run_id     = rec_rdata_reg.id;
                rsp_next.units_left = left_new;
                if (left_new == '0)
                begin
                    done_next[pick_reg]     = 1'b1;
                    rsp_next.first_run_time = start_val;
                    rsp_next.finish_time    = sat_inc(now_reg);
                    burst_next              = rec_rdata_reg.burst;
                    state_next              = S_TURN;
                end
                else
                begin
                    rsp_next.status = ST_RAN;
                    rsp_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_TURN:
            begin
                rsp_next.turnaround = floor_sub(rsp_reg.finish_time, TIME_W'(best_arr_reg));
                state_next          = S_WAIT;
            end

            S_WAIT:
            begin
                rsp_next.waiting = floor_sub(rsp_reg.turnaround, TIME_W'(burst_reg));
                rsp_next.status  = ST_DONE;
                rsp_valid_next   = 1'b1;
                state_next       = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            now_reg       <= '0;
            done_reg      <= '0;
            started_reg   <= '0;
            scan_addr_reg <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            now_reg       <= now_next;
            done_reg      <= done_next;
            started_reg   <= started_next;
            scan_addr_reg <= scan_addr_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= cmp_idx_next;
        best_prio_reg <= best_prio_next;
        best_arr_reg  <= best_arr_next;
        pick_reg      <= pick_next;
        burst_reg     <= burst_next;
        rsp_reg       <= rsp_next;
    end

    // Arrival and priority memory, read by the scan.
    always_ff @(posedge clk)
    begin
        if (sel_we)
        begin
            sel_mem[sel_waddr] <= sel_wdata;
        end
        sel_rdata_reg <= sel_mem[sel_raddr];
    end

    // Id, burst, remaining units and start time, read for the picked task.
    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[rec_waddr] <= rec_wdata;
        end
        rec_rdata_reg <= rec_mem[rec_raddr];
    end

    `PPS_ASSERT_IMP(a_cnt_range, 1'b1, count_reg <= CNT_MAX, "entry count beyond table size")
    `PPS_ASSERT_IMP(a_busy_no_rsp, state_reg != S_IDLE, !rsp_valid_reg, "result while busy")
    `PPS_ASSERT_IMP(a_pick_range, state_reg == S_READ, CNT_W'(pick_reg) < count_reg, "bad pick")
    `PPS_ASSERT_IMP(a_pop_idle, pop, state_reg == S_IDLE && rsp_free, "pop while busy")

endmodule

### hdl/preemptive_priority_scheduler_core.sv
// Top level of the preemptive priority scheduler.
//
//   Channel    Dir   Handshake     Contents
//   task_cmd   in    valid/ready   cmd, task_id, arrival_time, burst_length, prio_level
//   sched_rsp  out   valid/ready   status, times, run_id, units_left, figures
//
// Load and clear items finish in the idle state. A tick scans the loaded entries, reading
// the arrival/priority memory one entry per cycle, then reports idle if no task is ready,
// or reads and updates the picked task, with turnaround and waiting steps when it finishes.
// rst_n clears the table flags, entry count, time and queue asynchronously.
// A two-entry queue keeps accepting items, until it is full, while a result waits on sched_rsp.
module preemptive_priority_scheduler_core #(
    parameter int MAX_TASKS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    pps_cmd_if.sink   task_cmd,
    pps_rsp_if.source sched_rsp
);
    import pps_pkg::*;

    q_push_t   push;
    q_head_t   head;
    logic      full;
    logic      pop;
    rsp_item_t rsp_item;
    logic      rsp_valid;

    pps_front u_front (
        .cmd_ch (task_cmd),
        .push   (push),
        .full   (full)
    );

    pps_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .pop   (pop),
        .head  (head)
    );

    pps_exec #(
        .MAX_TASKS (MAX_TASKS)
    ) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .rsp_item  (rsp_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (sched_rsp.ready)
    );

    // Result channel.
    assign sched_rsp.valid          = rsp_valid;
    assign sched_rsp.status         = rsp_item.status;
    assign sched_rsp.tick_time      = rsp_item.tick_time;
    assign sched_rsp.run_id         = rsp_item.run_id;
    assign sched_rsp.units_left     = rsp_item.units_left;
    assign sched_rsp.first_run_time = rsp_item.first_run_time;
    assign sched_rsp.finish_time    = rsp_item.finish_time;
    assign sched_rsp.turnaround     = rsp_item.turnaround;
    assign sched_rsp.waiting        = rsp_item.waiting;

endmodule
